// File: sv/sva_pkg.sv
package sva_pkg;

  localparam int MAX_TERMS_DEF = 1024;
  localparam int ID_BITS_DEF   = 24;

  localparam int TERM_ID_W    = 24;
  localparam int WEIGHT_W     = 16;
  localparam int ANGLE_W      = 16;
  localparam int SUM_W        = 48;
  localparam int ROOT_W       = 32;
  localparam int RADICAND_W   = 64;
  localparam int COS_W        = 17;
  localparam int QUOT_W       = 30;
  localparam int DIV_STEPS    = 30;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W     = 24;
  localparam int ITER_W       = 5;

  localparam logic [COS_W-1:0]           COS_ONE     = 17'd65536;
  localparam logic signed [CORDIC_W-1:0] PI_Q20      = 24'sd3294199;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic [ANGLE_W-1:0]         ANGLE_MAX   = 16'd51472;

  typedef struct packed {
    logic                       list_select;
    logic [TERM_ID_W-1:0]       term_id;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       last_item;
  } item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               zero_norm;
    logic               list_overflow;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ENTRY, S_RD, S_CMP, S_MAC, S_POST,
    S_SQ1, S_SQ1W, S_SQ2, S_SQ2W, S_DEN, S_DVI, S_DIV, S_CLD, S_CSQ,
    S_SQ3, S_SQ3W, S_CORI, S_COR, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    SQ_FIRST, SQ_SECOND, SQ_SINE
  } sqrt_src_t;

  typedef struct packed {
    logic      latch;
    logic      first_wr;
    logic      n2_add;
    logic      rd_issue;
    logic      mp_inc;
    logic      prod_load;
    logic      dot_add;
    logic      sqrt_start;
    sqrt_src_t sqrt_src;
    logic      r1_load;
    logic      r2_load;
    logic      den_load;
    logic      div_init;
    logic      div_step;
    logic      c_load;
    logic      csq_load;
    logic      s_load;
    logic      cordic_init;
    logic      cordic_step;
    logic      result_load;
  } cmd_t;

  typedef struct packed {
    logic sel;
    logic last;
    logic full;
    logic mp_lt;
    logic id_lt;
    logic id_eq;
    logic any_zero;
    logic sqrt_done;
    logic mag_ge_den;
    logic div_last;
    logic cor_last;
    logic out_free;
  } status_t;

  // Arctangent of 2^-i in Q2.20.
  function automatic logic signed [CORDIC_W-1:0] atan_q20(input logic [ITER_W-1:0] i);
    logic signed [CORDIC_W-1:0] a;
    unique case (i)
      5'd0:    a = 24'sd823550;
      5'd1:    a = 24'sd486170;
      5'd2:    a = 24'sd256879;
      5'd3:    a = 24'sd130396;
      5'd4:    a = 24'sd65451;
      5'd5:    a = 24'sd32757;
      5'd6:    a = 24'sd16383;
      5'd7:    a = 24'sd8192;
      5'd8:    a = 24'sd4096;
      5'd9:    a = 24'sd2048;
      5'd10:   a = 24'sd1024;
      5'd11:   a = 24'sd512;
      5'd12:   a = 24'sd256;
      5'd13:   a = 24'sd128;
      5'd14:   a = 24'sd64;
      5'd15:   a = 24'sd32;
      5'd16:   a = 24'sd16;
      5'd17:   a = 24'sd8;
      5'd18:   a = 24'sd4;
      5'd19:   a = 24'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: sv/sva_ram.sv
module sva_ram
  import sva_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/sva_isqrt.sv
module sva_isqrt
  import sva_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RADICAND_W-1:0] operand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  // One result bit per cycle, two radicand bits consumed per cycle.
  logic [RADICAND_W-1:0] opnd;
  logic [ROOT_W+2:0]     rem;
  logic [5:0]            cnt;
  logic                  busy;
  logic [ROOT_W+2:0]     rem_sh;
  logic [ROOT_W+2:0]     trial;

  assign rem_sh = {rem[ROOT_W:0], opnd[RADICAND_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      opnd <= {opnd[RADICAND_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: sv/sva_ctrl.sv
module sva_ctrl
  import sva_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (item_valid) state_next = S_ENTRY;
      S_ENTRY: state_next = stat.sel ? S_RD : S_IDLE;
      S_RD:    state_next = stat.mp_lt ? S_CMP : S_POST;
      S_CMP: begin
        priority if (stat.id_lt) state_next = S_RD;
        else if (stat.id_eq)     state_next = S_MAC;
        else                     state_next = S_POST;
      end
      S_MAC: state_next = S_POST;
      S_POST: begin
        priority if (!stat.last) state_next = S_IDLE;
        else if (stat.any_zero)  state_next = S_FIN;
        else                     state_next = S_SQ1;
      end
      S_SQ1:  state_next = S_SQ1W;
      S_SQ1W: if (stat.sqrt_done) state_next = S_SQ2;
      S_SQ2:  state_next = S_SQ2W;
      S_SQ2W: if (stat.sqrt_done) state_next = S_DEN;
      S_DEN:  state_next = S_DVI;
      S_DVI:  state_next = stat.mag_ge_den ? S_CLD : S_DIV;
      S_DIV:  if (stat.div_last) state_next = S_CLD;
      S_CLD:  state_next = S_CSQ;
      S_CSQ:  state_next = S_SQ3;
      S_SQ3:  state_next = S_SQ3W;
      S_SQ3W: if (stat.sqrt_done) state_next = S_CORI;
      S_CORI: state_next = S_COR;
      S_COR:  if (stat.cor_last) state_next = S_FIN;
      S_FIN:  if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.latch  = item_valid;
      end
      S_ENTRY: begin
        cmd.first_wr = !stat.sel;
        cmd.n2_add   = stat.sel;
      end
      S_RD:  cmd.rd_issue = stat.mp_lt;
      S_CMP: begin
        cmd.mp_inc    = stat.id_lt;
        cmd.prod_load = !stat.id_lt && stat.id_eq;
      end
      S_MAC: begin
        cmd.dot_add = 1'b1;
        cmd.mp_inc  = 1'b1;
      end
      S_SQ1: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_src   = SQ_FIRST;
      end
      S_SQ1W: cmd.r1_load = stat.sqrt_done;
      S_SQ2: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_src   = SQ_SECOND;
      end
      S_SQ2W: cmd.r2_load  = stat.sqrt_done;
      S_DEN:  cmd.den_load = 1'b1;
      S_DVI:  cmd.div_init = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_CLD:  cmd.c_load   = 1'b1;
      S_CSQ:  cmd.csq_load = 1'b1;
      S_SQ3: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_src   = SQ_SINE;
      end
      S_SQ3W: cmd.s_load      = stat.sqrt_done;
      S_CORI: cmd.cordic_init = 1'b1;
      S_COR:  cmd.cordic_step = 1'b1;
      S_FIN:  cmd.result_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/sva_dp.sv
module sva_dp
  import sva_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output status_t stat,
  output result_t result,
  output logic    result_valid,
  input  logic    result_ready
);

  localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int RAM_W  = ID_BITS + WEIGHT_W;

  function automatic logic signed [CORDIC_W-1:0] shr_trunc(
    input logic signed [CORDIC_W-1:0] v, input logic [ITER_W-1:0] s);
    logic [CORDIC_W-1:0] mag;
    mag = v[CORDIC_W-1] ? unsigned'(-v) : unsigned'(v);
    mag = mag >> s;
    return v[CORDIC_W-1] ? -signed'(mag) : signed'(mag);
  endfunction

  // Latched input beat.
  logic                       sel_r;
  logic                       last_r;
  logic [ID_BITS-1:0]         id_r;
  logic signed [WEIGHT_W-1:0] w_r;
  logic [31:0]                sq_r;
  logic signed [31:0]         sq_s;

  // Accumulation state.
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       mp;
  logic [SUM_W-1:0]       n1;
  logic [SUM_W-1:0]       n2;
  logic signed [SUM_W-1:0] dot;
  logic                   ovf;
  logic signed [31:0]     prod_r;

  logic [RAM_W-1:0]           rdata;
  logic [ID_BITS-1:0]         st_id;
  logic signed [WEIGHT_W-1:0] st_w;

  logic [SUM_W:0]          n1_sum;
  logic [SUM_W:0]          n2_sum;
  logic signed [SUM_W:0]   dot_sum;

  // Angle pipeline.
  logic [RADICAND_W-1:0]   sq_operand;
  logic                    sq_done;
  logic [ROOT_W-1:0]       sq_root;
  logic [ROOT_W-1:0]       r1;
  logic [ROOT_W-1:0]       r2;
  logic [63:0]             den;
  logic [SUM_W-1:0]        mag;
  logic [63:0]             rem_d;
  logic [63:0]             rem_sh;
  logic [QUOT_W-1:0]       quot;
  logic [ITER_W-1:0]       iter;
  logic [COS_W-1:0]        cosv;
  logic [32:0]             v_r;
  logic [2*COS_W-1:0]      csq;
  logic [COS_W-1:0]        sinv;
  logic signed [CORDIC_W-1:0] cx, cy, cz;
  logic signed [CORDIC_W-1:0] shx, shy;
  logic signed [CORDIC_W-1:0] zc, za;
  logic [ANGLE_W-1:0]      angle_c;

  assign sq_s = item.weight * item.weight;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sel_r  <= item.list_select;
      last_r <= item.last_item;
      id_r   <= ID_BITS'(item.term_id);
      w_r    <= item.weight;
      sq_r   <= unsigned'(sq_s);
    end
  end

  sva_ram #(.WIDTH(RAM_W), .DEPTH(MAX_TERMS)) u_store (
    .clk   (clk),
    .we    (cmd.first_wr && !stat.full),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({id_r, w_r}),
    .re    (cmd.rd_issue),
    .raddr (mp[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign st_id = rdata[RAM_W-1:WEIGHT_W];
  assign st_w  = signed'(rdata[WEIGHT_W-1:0]);

  assign n1_sum  = {1'b0, n1} + (SUM_W+1)'(sq_r);
  assign n2_sum  = {1'b0, n2} + (SUM_W+1)'(sq_r);
  assign dot_sum = {dot[SUM_W-1], dot} + (SUM_W+1)'(prod_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mp    <= '0;
      n1    <= '0;
      n2    <= '0;
      dot   <= '0;
      ovf   <= 1'b0;
    end else if (cmd.result_load) begin
      count <= '0;
      mp    <= '0;
      n1    <= '0;
      n2    <= '0;
      dot   <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.first_wr) begin
        if (stat.full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
          n1    <= n1_sum[SUM_W] ? '1 : n1_sum[SUM_W-1:0];
        end
      end
      if (cmd.n2_add) begin
        n2 <= n2_sum[SUM_W] ? '1 : n2_sum[SUM_W-1:0];
      end
      if (cmd.mp_inc) begin
        mp <= mp + CNT_W'(1);
      end
      if (cmd.dot_add) begin
        if (!dot_sum[SUM_W] && dot_sum[SUM_W-1]) begin
          dot <= {1'b0, {(SUM_W-1){1'b1}}};
        end else if (dot_sum[SUM_W] && !dot_sum[SUM_W-1]) begin
          dot <= {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
          dot <= dot_sum[SUM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_load) begin
      prod_r <= st_w * w_r;
    end
  end

  always_comb begin
    unique case (cmd.sqrt_src)
      SQ_FIRST:  sq_operand = {2'b00, n1, 14'd0};
      SQ_SECOND: sq_operand = {2'b00, n2, 14'd0};
      SQ_SINE:   sq_operand = RADICAND_W'(v_r);
      default:   sq_operand = '0;
    endcase
  end

  sva_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.sqrt_start),
    .operand (sq_operand),
    .done    (sq_done),
    .root    (sq_root)
  );

  assign rem_sh = {rem_d[62:0], 1'b0};
  assign csq    = cosv * cosv;
  assign shx    = shr_trunc(cx, iter);
  assign shy    = shr_trunc(cy, iter);

  always_ff @(posedge clk) begin
    if (cmd.r1_load) r1 <= sq_root;
    if (cmd.r2_load) r2 <= sq_root;
    if (cmd.den_load) begin
      den <= r1 * r2;
      mag <= dot[SUM_W-1] ? unsigned'(-dot) : unsigned'(dot);
    end
    if (cmd.div_init) begin
      rem_d <= 64'(mag);
      quot  <= '0;
      iter  <= '0;
    end else if (cmd.div_step) begin
      iter <= iter + ITER_W'(1);
      if (rem_sh >= den) begin
        rem_d <= rem_sh - den;
        quot  <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem_d <= rem_sh;
        quot  <= {quot[QUOT_W-2:0], 1'b0};
      end
    end else if (cmd.cordic_init) begin
      iter <= '0;
    end else if (cmd.cordic_step) begin
      iter <= iter + ITER_W'(1);
    end
    if (cmd.c_load) begin
      cosv <= (stat.mag_ge_den || quot > QUOT_W'(COS_ONE)) ? COS_ONE : quot[COS_W-1:0];
    end
    if (cmd.csq_load) begin
      v_r <= 33'h1_0000_0000 - csq[32:0];
    end
    if (cmd.s_load) begin
      sinv <= sq_root[COS_W-1:0];
    end
    if (cmd.cordic_init) begin
      cx <= CORDIC_W'(cosv);
      cy <= CORDIC_W'(sinv);
      cz <= '0;
    end else if (cmd.cordic_step) begin
      if (cy > 0) begin
        cx <= cx + shy;
        cy <= cy - shx;
        cz <= cz + atan_q20(iter);
      end else begin
        cx <= cx - shy;
        cy <= cy + shx;
        cz <= cz - atan_q20(iter);
      end
    end
  end

  always_comb begin
    priority if (cz < 0)     zc = '0;
    else if (cz > HALF_PI_Q20) zc = HALF_PI_Q20;
    else                     zc = cz;
    if (dot[SUM_W-1]) begin
      zc = PI_Q20 - zc;
    end
    za = (zc + CORDIC_W'(32)) >>> 6;
    angle_c = (za > CORDIC_W'(ANGLE_MAX)) ? ANGLE_MAX : za[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      result.zero_norm     <= stat.any_zero;
      result.angle         <= stat.any_zero ? '0 : angle_c;
      result.list_overflow <= ovf;
    end
  end

  always_comb begin
    stat            = '0;
    stat.sel        = sel_r;
    stat.last       = last_r;
    stat.full       = (count >= CNT_W'(MAX_TERMS));
    stat.mp_lt      = (mp < count);
    stat.id_lt      = (st_id < id_r);
    stat.id_eq      = (st_id == id_r);
    stat.any_zero   = (n1 == '0) || (n2 == '0);
    stat.sqrt_done  = sq_done;
    stat.mag_ge_den = (64'(mag) >= den);
    stat.div_last   = (iter == ITER_W'(DIV_STEPS - 1));
    stat.cor_last   = (iter == ITER_W'(CORDIC_STEPS - 1));
    stat.out_free   = !result_valid || result_ready;
  end

`ifndef NO_ASSERTIONS
  a_mp_bound: assert property (@(posedge clk) disable iff (rst) mp <= count)
    else $error("merge pointer passed the stored count");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TERMS))
    else $error("stored count beyond capacity");
  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_norm |-> result.angle == '0)
    else $error("zero norm result with nonzero angle");
  a_angle_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.angle <= ANGLE_MAX)
    else $error("angle above pi");
`endif

endmodule

// File: sv/sparse_vector_angle.sv
// Angle between two sparse term-weight vectors. Each input beat carries one
// (term id, Q3.12 weight) entry. First-list entries (list_select = 0) are
// stored in an on-chip memory of MAX_TERMS entries. Entries beyond capacity
// are dropped and flagged. For a second-list entry the merge pointer steps
// past every stored entry with a smaller id, and stops at the end of the
// stored list or at a larger or matching stored id; a matching id adds the
// weight product to the dot sum. Each step is one read of the single memory
// read port. The last second-list entry then starts the angle computation,
// unless a norm is zero: two integer square roots for the norms, a restoring
// division for the cosine, a third square root for the sine and 20 CORDIC
// steps for the arctangent, with all three square roots on one shared
// iterative unit. One result beat (Q2.14 angle, zero-norm and overflow
// flags) is held in an output register, and the block accepts the next
// input beat while that result waits. All accumulated state clears when
// the result is produced.
module sparse_vector_angle
  import sva_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  cmd_t    cmd;
  status_t stat;

  // The controller sequences the merge and the angle units.
  sva_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the stored list, the sums and the arithmetic units.
  sva_dp #(.MAX_TERMS(MAX_TERMS), .ID_BITS(ID_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
